@@ rtl/playfair_digraph_encrypt_assert.svh @@
// assertion macros shared by the playfair digraph checker
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PDE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("playfair digraph assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("playfair digraph assertion failed");

`endif

@@ rtl/pde_pkg.sv @@
// types, constants and letter helpers for the playfair digraph encryptor
package pde_pkg;

  localparam int LetterW = 5;
  localparam int Side    = 5;
  localparam int Cells   = Side * Side;
  localparam int CellsPerWord = 12;
  localparam int CfgDataW = CellsPerWord * LetterW;
  localparam int CfgIndexW = 2;
  localparam int FifoDepth = 4;
  localparam int PtrW = $clog2(FifoDepth);
  localparam int CountW = $clog2(FifoDepth + 1);
  localparam int PosW = 3;

  localparam logic [LetterW-1:0] Alpha     = 5'd26;
  localparam logic [LetterW-1:0] PadOffset = 5'd15;
  localparam logic [LetterW-1:0] LetterA   = 5'd0;
  localparam logic [LetterW-1:0] LetterE   = 5'd4;
  localparam logic [LetterW-1:0] LetterI   = 5'd8;
  localparam logic [LetterW-1:0] LetterJ   = 5'd9;
  localparam logic [LetterW-1:0] LetterO   = 5'd14;
  localparam logic [LetterW-1:0] LetterU   = 5'd20;
  localparam logic [LetterW-1:0] SideW     = 5'd5;
  localparam logic [PosW-1:0]    LastPos   = 3'd4;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_CELLS_LOW  = 2'd0,
    CFG_CELLS_HIGH = 2'd1,
    CFG_CELL_FINAL = 2'd2
  } cfg_index_t;

  typedef logic [Cells-1:0][LetterW-1:0] square_t;

  // one digraph waiting to be enciphered
  typedef struct packed {
    logic [LetterW-1:0] p_letter;
    logic               p_lower;
    logic [LetterW-1:0] q_letter;
    logic               q_lower;
    logic               last;
  } pair_t;

  // one enciphered digraph
  typedef struct packed {
    logic [LetterW-1:0] p_cipher;
    logic               p_lower;
    logic [LetterW-1:0] q_cipher;
    logic               q_lower;
    logic               last;
  } cipher_pair_t;

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } pos_t;

  function automatic logic [LetterW-1:0] fold_j(input logic [LetterW-1:0] x);
    return (x == LetterJ) ? LetterI : x;
  endfunction

  // (x + 15) mod 26 for x below 26
  function automatic logic [LetterW-1:0] pad_of(input logic [LetterW-1:0] x);
    logic [LetterW:0] sum;
    sum = {1'b0, x} + {1'b0, PadOffset};
    if (sum >= {1'b0, Alpha}) begin
      sum = sum - {1'b0, Alpha};
    end
    return sum[LetterW-1:0];
  endfunction

  // pad letter stepped past a vowel
  function automatic logic [LetterW-1:0] filler_of(input logic [LetterW-1:0] x);
    logic [LetterW-1:0] f;
    f = pad_of(x);
    if (f == LetterA || f == LetterE || f == LetterI || f == LetterO || f == LetterU) begin
      f = f + 5'd1;
    end
    return f;
  endfunction

  // lowest cell holding x, cell 0 when absent
  function automatic pos_t locate(input square_t sq, input logic [LetterW-1:0] x);
    pos_t pos;
    pos = '0;
    for (int r = Side - 1; r >= 0; r--) begin
      for (int c = Side - 1; c >= 0; c--) begin
        if (sq[r * Side + c] == x) begin
          pos.row = PosW'(r);
          pos.col = PosW'(c);
        end
      end
    end
    return pos;
  endfunction

  function automatic logic [PosW-1:0] wrap_inc(input logic [PosW-1:0] v);
    return (v == LastPos) ? '0 : v + 3'd1;
  endfunction

  function automatic logic [LetterW-1:0] cell_of(input pos_t pos);
    logic [LetterW-1:0] r5;
    r5 = {2'b00, pos.row};
    return LetterW'(r5 * SideW) + {2'b00, pos.col};
  endfunction

endpackage

@@ rtl/pde_pair_encode.sv @@
// key square lookup and playfair substitution for one digraph
module pde_pair_encode
  import pde_pkg::*;
(
  input  square_t      sq,
  input  pair_t        pair,
  output cipher_pair_t result
);

  pos_t pa, pb, oa, ob;

  always_comb begin
    pa = locate(sq, pair.p_letter);
    pb = locate(sq, pair.q_letter);
    priority if (pa.col == pb.col) begin
      oa = '{row: wrap_inc(pa.row), col: pa.col};
      ob = '{row: wrap_inc(pb.row), col: pb.col};
    end else if (pa.row == pb.row) begin
      oa = '{row: pa.row, col: wrap_inc(pa.col)};
      ob = '{row: pb.row, col: wrap_inc(pb.col)};
    end else begin
      oa = '{row: pa.row, col: pb.col};
      ob = '{row: pb.row, col: pa.col};
    end
  end

  assign result.p_cipher = sq[cell_of(oa)];
  assign result.q_cipher = sq[cell_of(ob)];
  assign result.p_lower  = pair.p_lower;
  assign result.q_lower  = pair.q_lower;
  assign result.last     = pair.last;

endmodule

@@ rtl/playfair_digraph_encrypt.sv @@
// playfair digraph encryptor: letter pairing, digraph queue, cipher and output stage
// path: an item's digraphs pass through the digraph queue and then the output stage to out_valid
// throughput: one result per cycle through the single output port while out_ready is held;
//   an item yields 0, 2 or 4 results, and a new item can be taken before earlier results are out
// reset: drops a held letter, empties the digraph queue and output stage, and clears
//   the key square to zeros (load it before sending letters)
module playfair_digraph_encrypt
  import pde_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  // plaintext letters
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [LetterW-1:0]   in_plain_letter,
  input  logic                 in_plain_lower,
  input  logic                 in_end_of_text,
  // ciphertext letters
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LetterW-1:0]   out_cipher_letter,
  output logic                 out_cipher_lower,
  output logic                 out_run_last
);

  // key square, held as flops since every cell is compared at once
  square_t sq_r;

  // open pair: first letter waiting for its partner
  logic               held_valid_r, held_valid_nxt;
  logic [LetterW-1:0] held_letter_r, held_letter_nxt;
  logic               held_lower_r, held_lower_nxt;

  // digraph queue between pairing and the cipher stage
  pair_t             fifo_r [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CountW-1:0] count_r, count_nxt;

  // output stage: one enciphered digraph, shown p letter first
  cipher_pair_t obuf_r;
  logic         obuf_valid_r;
  logic         obuf_idx_r;

  logic               in_fire, out_fire, drain, pop;
  logic [LetterW-1:0] x_wrap, x;
  logic [1:0]         npush;
  pair_t              push_a, push_b;
  cipher_pair_t       enc_result;

  // ---------------------------------------------------------------
  // configuration: always ready, cells unpacked five bits each
  // ---------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CELLS_LOW: begin
          for (int i = 0; i < CellsPerWord; i++) begin
            sq_r[i] <= cfg_data[i*LetterW +: LetterW];
          end
        end
        CFG_CELLS_HIGH: begin
          for (int i = 0; i < CellsPerWord; i++) begin
            sq_r[CellsPerWord + i] <= cfg_data[i*LetterW +: LetterW];
          end
        end
        CFG_CELL_FINAL: begin
          sq_r[Cells-1] <= cfg_data[LetterW-1:0];
        end
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // pairing: out-of-range letters wrap, J folds to I, then 0..2
  // digraphs are pushed per item depending on the open pair
  // ---------------------------------------------------------------
  assign in_ready = (count_r <= CountW'(FifoDepth - 2));
  assign in_fire  = in_valid && in_ready;

  assign x_wrap = (in_plain_letter >= Alpha) ? in_plain_letter - Alpha : in_plain_letter;
  assign x      = fold_j(x_wrap);

  always_comb begin
    npush           = 2'd0;
    push_a          = '0;
    push_b          = '0;
    held_valid_nxt  = held_valid_r;
    held_letter_nxt = held_letter_r;
    held_lower_nxt  = held_lower_r;
    if (in_fire) begin
      priority if (!held_valid_r) begin
        if (in_end_of_text) begin
          // lone last letter, padded without the vowel step
          npush  = 2'd1;
          push_a = '{p_letter: x, p_lower: in_plain_lower,
                     q_letter: fold_j(pad_of(x)), q_lower: 1'b0, last: 1'b1};
        end else begin
          held_valid_nxt  = 1'b1;
          held_letter_nxt = x;
          held_lower_nxt  = in_plain_lower;
        end
      end else if (held_letter_r != x) begin
        // ordinary pair closes the open one
        npush          = 2'd1;
        push_a         = '{p_letter: held_letter_r, p_lower: held_lower_r,
                           q_letter: x, q_lower: in_plain_lower, last: 1'b1};
        held_valid_nxt = 1'b0;
      end else begin
        // doubled letter: filler splits it, new letter opens the next pair
        npush  = 2'd1;
        push_a = '{p_letter: held_letter_r, p_lower: held_lower_r,
                   q_letter: fold_j(filler_of(held_letter_r)), q_lower: 1'b0,
                   last: !in_end_of_text};
        if (in_end_of_text) begin
          npush          = 2'd2;
          push_b         = '{p_letter: x, p_lower: in_plain_lower,
                             q_letter: fold_j(pad_of(x)), q_lower: 1'b0, last: 1'b1};
          held_valid_nxt = 1'b0;
        end else begin
          held_letter_nxt = x;
          held_lower_nxt  = in_plain_lower;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_letter_r <= '0;
      held_lower_r  <= 1'b0;
    end else begin
      held_valid_r  <= held_valid_nxt;
      held_letter_r <= held_letter_nxt;
      held_lower_r  <= held_lower_nxt;
    end
  end

  // ---------------------------------------------------------------
  // digraph queue: up to two pushes and one pop a cycle
  // ---------------------------------------------------------------
  assign out_fire = out_valid && out_ready;
  assign drain    = out_fire && obuf_idx_r;
  assign pop      = (count_r != '0) && (!obuf_valid_r || drain);

  assign count_nxt = count_r + CountW'(npush) - CountW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PtrW'(npush);
      rd_ptr_r <= rd_ptr_r + PtrW'(pop);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      fifo_r[wr_ptr_r] <= push_a;
    end
    if (npush == 2'd2) begin
      fifo_r[wr_ptr_r + PtrW'(1)] <= push_b;
    end
  end

  // ---------------------------------------------------------------
  // cipher stage: queue head through the square into the output stage
  // ---------------------------------------------------------------
  pde_pair_encode u_encode (
    .sq     (sq_r),
    .pair   (fifo_r[rd_ptr_r]),
    .result (enc_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obuf_valid_r <= 1'b0;
      obuf_idx_r   <= 1'b0;
    end else if (pop) begin
      obuf_valid_r <= 1'b1;
      obuf_idx_r   <= 1'b0;
    end else if (drain) begin
      obuf_valid_r <= 1'b0;
      obuf_idx_r   <= 1'b0;
    end else if (out_fire) begin
      obuf_idx_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      obuf_r <= enc_result;
    end
  end

  // second letter of a digraph carries the item's last mark
  assign out_valid         = obuf_valid_r;
  assign out_cipher_letter = obuf_idx_r ? obuf_r.q_cipher : obuf_r.p_cipher;
  assign out_cipher_lower  = obuf_idx_r ? obuf_r.q_lower : obuf_r.p_lower;
  assign out_run_last      = obuf_idx_r && obuf_r.last;

endmodule

@@ rtl/pde_checker.sv @@
// port-level checker for the playfair digraph encryptor, bound to the top level
`include "playfair_digraph_encrypt_assert.svh"

module pde_checker
  import pde_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [LetterW-1:0]   out_cipher_letter,
  input logic                 out_cipher_lower,
  input logic                 out_run_last
);

  // high while the second letter of a digraph is on the port
  logic parity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      parity_r <= !parity_r;
    end
  end

  `PDE_ASSERT_NEXT(a_out_valid_hold, out_valid && !out_ready, out_valid)
  `PDE_ASSERT_NEXT(a_out_payload_hold, out_valid && !out_ready, $stable(out_cipher_letter) && $stable(out_cipher_lower) && $stable(out_run_last))
  `PDE_ASSERT_IMPL(a_last_closes_pair, out_valid && out_run_last, parity_r)
  `PDE_ASSERT_NEXT(a_pair_contiguous, out_valid && out_ready && !parity_r, out_valid)
  `PDE_ASSERT_IMPL(a_stall_only_when_busy, !in_ready, out_valid)

endmodule

bind playfair_digraph_encrypt pde_checker u_pde_checker (.*);
